/* rtl/core/ptp_pkg.sv */
// Package for the phoneme token parser.
// Holds the result type, operation and result codes, and reset constants.
// No dependencies.
package ptp_pkg;

    localparam int PH_W = 7;
    localparam int STRESS_W = 4;

    localparam logic [1:0] OP_PARSE = 2'd0;
    localparam logic [1:0] OP_LOAD_NAME = 2'd1;
    localparam logic [1:0] OP_LOAD_STRESS = 2'd2;

    localparam logic [1:0] KIND_PHONEME = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] CFG_NAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_END_MARKER = 2'd1;

    localparam logic [7:0] WILDCARD = 8'd42;
    localparam logic [7:0] NAME_COUNT_RST = 8'd81;
    localparam logic [7:0] END_MARKER_RST = 8'd155;

    typedef struct packed {
        logic [1:0]          kind;
        logic [PH_W-1:0]     phoneme;
        logic [STRESS_W-1:0] stress_level;
        logic                last;
    } result_t;

endpackage

/* rtl/core/ptp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ptp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/ptp_stress_table.sv */
// Stress character table with a parallel lookup of the highest matching level.
// Depends on ptp_pkg.
module ptp_stress_table #(
    parameter int STRESS_SLOTS = 9
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [6:0]                     wr_slot,
    input  logic [7:0]                     wr_data,
    input  logic [7:0]                     key,
    output logic [ptp_pkg::STRESS_W-1:0]   level
);

    import ptp_pkg::*;

    logic [7:0] stress_mem [STRESS_SLOTS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STRESS_SLOTS; i++)
        begin
            if (wr_en && (wr_slot == 7'(i)))
            begin
                stress_mem[i] <= wr_data;
            end
        end
    end

    always_comb
    begin
        level = '0;
        for (int i = 1; i < STRESS_SLOTS; i++)
        begin
            if (stress_mem[i] == key)
            begin
                level = STRESS_W'(i);
            end
        end
    end

endmodule

/* rtl/core/ptp_out_fifo.sv */
// Two-entry result queue that decouples the parser from the output channel.
// Depends on ptp_pkg.
module ptp_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ptp_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output ptp_pkg::result_t out_data
);

    import ptp_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign full = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data = entry_reg[rd_ptr_reg];
    assign pop = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The parser only pushes when there is room.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Result pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("Result queue count out of range.");

endmodule

/* rtl/core/phoneme_token_parser_core.sv */
// Phoneme token parser: tokenizes phoneme-text bytes against a loaded table.
// Load operations do not leave the idle state; a parse byte with no pending byte goes
// straight to the decision step, and one with a pending byte first scans the name RAM one
// entry per cycle, min(name_count, NAME_SLOTS) entries; results wait for room in the queue.
// Reset is asynchronous, clears the parse state but the current byte and staged results,
// and loads register defaults; name and stress tables are undefined until loaded.
module phoneme_token_parser_core #(
    parameter int NAME_SLOTS = 128,
    parameter int STRESS_SLOTS = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [7:0]                   ch,
    input  logic [7:0]                   second_ch,
    input  logic [6:0]                   slot,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic [ptp_pkg::PH_W-1:0]     phoneme,
    output logic [ptp_pkg::STRESS_W-1:0] stress_level,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [7:0]                   cfg_data
);

    import ptp_pkg::*;

    localparam int AW = $clog2(NAME_SLOTS);
    localparam int CW = $clog2(NAME_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [7:0]          name_count_reg;
    logic [7:0]          end_marker_reg;
    logic [7:0]          cur_ch_reg;
    logic [7:0]          pending_byte_reg;
    logic [7:0]          pending_byte_next;
    logic                pending_valid_reg;
    logic                pending_valid_next;
    logic [PH_W-1:0]     held_phoneme_reg;
    logic [PH_W-1:0]     held_phoneme_next;
    logic                held_valid_reg;
    logic                held_valid_next;
    logic [STRESS_W-1:0] held_stress_reg;
    logic [STRESS_W-1:0] held_stress_next;

    logic [CW-1:0]       lim_reg;
    logic [CW-1:0]       lim;
    logic [CW-1:0]       issue_idx_reg;
    logic                rd_live_reg;
    logic [AW-1:0]       data_idx_reg;
    logic                pair_found_reg;
    logic [AW-1:0]       pair_idx_reg;
    logic                wild_found_reg;
    logic [AW-1:0]       wild_idx_reg;

    result_t             res_reg [2];
    result_t             res_next [2];
    logic [1:0]          res_cnt_reg;
    logic [1:0]          res_cnt_next;
    logic                emit_idx_reg;

    logic                in_fire;
    logic                issue;
    logic [15:0]         rd_data;
    logic                is_end;
    logic                done;
    logic                pair_hit;
    logic                wild_hit;
    logic [STRESS_W-1:0] stress_lvl;
    logic                fifo_full;
    logic                push;
    result_t             out_data;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign is_end = (cur_ch_reg == end_marker_reg);
    assign issue = (state_reg == ST_SCAN) && (issue_idx_reg < lim_reg);
    assign lim = ({1'b0, name_count_reg} > 9'(NAME_SLOTS)) ? CW'(NAME_SLOTS)
                                                            : CW'(name_count_reg);

    ptp_ram #(
        .WIDTH(16),
        .DEPTH(NAME_SLOTS)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (in_fire && (op == OP_LOAD_NAME) && ({2'b00, slot} < 9'(NAME_SLOTS))),
        .wr_addr (AW'(slot)),
        .wr_data ({ch, second_ch}),
        .rd_en   (issue),
        .rd_addr (issue_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    ptp_stress_table #(
        .STRESS_SLOTS(STRESS_SLOTS)
    ) u_stress (
        .clk     (clk),
        .wr_en   (in_fire && (op == OP_LOAD_STRESS)),
        .wr_slot (slot),
        .wr_data (ch),
        .key     (pending_byte_reg),
        .level   (stress_lvl)
    );

    assign pair_hit = rd_live_reg && !pair_found_reg && !is_end
                      && (rd_data[15:8] == pending_byte_reg)
                      && (rd_data[7:0] != WILDCARD)
                      && (rd_data[7:0] == cur_ch_reg);
    assign wild_hit = rd_live_reg && !wild_found_reg
                      && (rd_data[15:8] == pending_byte_reg)
                      && (rd_data[7:0] == WILDCARD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_count_reg <= NAME_COUNT_RST;
            end_marker_reg <= END_MARKER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_NAME_COUNT)
            begin
                name_count_reg <= cfg_data;
            end
            else if (cfg_index == CFG_END_MARKER)
            begin
                end_marker_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_phoneme_next = held_phoneme_reg;
        held_stress_next = held_stress_reg;
        pending_byte_next = pending_byte_reg;
        pending_valid_next = 1'b0;
        res_next[0] = '0;
        res_next[1] = '0;
        res_cnt_next = 2'd0;
        done = 1'b0;
        if (pending_valid_reg)
        begin
            if (pair_found_reg || wild_found_reg)
            begin
                if (held_valid_next)
                begin
                    res_next[res_cnt_next[0]] = '{KIND_PHONEME, held_phoneme_next,
                                                  held_stress_next, 1'b0};
                    res_cnt_next = res_cnt_next + 2'd1;
                end
                held_phoneme_next = pair_found_reg ? PH_W'(pair_idx_reg)
                                                   : PH_W'(wild_idx_reg);
                held_stress_next = '0;
                held_valid_next = 1'b1;
                done = pair_found_reg;
            end
            else if (stress_lvl == '0)
            begin
                res_next[0] = '{KIND_ERROR, '0, '0, 1'b1};
                res_cnt_next = 2'd1;
                held_valid_next = 1'b0;
                held_phoneme_next = '0;
                held_stress_next = '0;
                done = 1'b1;
            end
            else if (held_valid_next)
            begin
                held_stress_next = stress_lvl;
            end
        end
        if (!done)
        begin
            if (is_end)
            begin
                if (held_valid_next)
                begin
                    res_next[res_cnt_next[0]] = '{KIND_PHONEME, held_phoneme_next,
                                                  held_stress_next, 1'b1};
                end
                else
                begin
                    res_next[res_cnt_next[0]] = '{KIND_END, '0, '0, 1'b1};
                end
                res_cnt_next = res_cnt_next + 2'd1;
                held_valid_next = 1'b0;
                held_phoneme_next = '0;
                held_stress_next = '0;
            end
            else
            begin
                pending_byte_next = cur_ch_reg;
                pending_valid_next = 1'b1;
            end
        end
    end

    assign push = (state_reg == ST_EMIT) && !fifo_full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (op == OP_PARSE))
                begin
                    state_next = pending_valid_reg ? ST_SCAN : ST_DECIDE;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !rd_live_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (res_cnt_next == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (push && ({1'b0, emit_idx_reg} + 2'd1 == res_cnt_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pending_byte_reg <= '0;
            pending_valid_reg <= 1'b0;
            held_phoneme_reg <= '0;
            held_valid_reg <= 1'b0;
            held_stress_reg <= '0;
            rd_live_reg <= 1'b0;
            issue_idx_reg <= '0;
            lim_reg <= '0;
            pair_found_reg <= 1'b0;
            wild_found_reg <= 1'b0;
            res_cnt_reg <= 2'd0;
            emit_idx_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_live_reg <= issue;
            if (state_reg == ST_IDLE)
            begin
                issue_idx_reg <= '0;
                lim_reg <= lim;
                pair_found_reg <= 1'b0;
                wild_found_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (issue)
                begin
                    issue_idx_reg <= issue_idx_reg + CW'(1);
                end
                if (pair_hit)
                begin
                    pair_found_reg <= 1'b1;
                end
                if (wild_hit)
                begin
                    wild_found_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DECIDE)
            begin
                pending_byte_reg <= pending_byte_next;
                pending_valid_reg <= pending_valid_next;
                held_phoneme_reg <= held_phoneme_next;
                held_valid_reg <= held_valid_next;
                held_stress_reg <= held_stress_next;
                res_cnt_reg <= res_cnt_next;
                emit_idx_reg <= 1'b0;
            end
            else if (push)
            begin
                emit_idx_reg <= !emit_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_ch_reg <= ch;
        end
        if (state_reg == ST_SCAN)
        begin
            data_idx_reg <= issue_idx_reg[AW-1:0];
            if (pair_hit)
            begin
                pair_idx_reg <= data_idx_reg;
            end
            if (wild_hit)
            begin
                wild_idx_reg <= data_idx_reg;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
        end
    end

    ptp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res_reg[emit_idx_reg]),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind = out_data.kind;
    assign phoneme = out_data.phoneme;
    assign stress_level = out_data.stress_level;
    assign last = out_data.last;

    // A result transaction is only staged when the decision produced one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (res_cnt_reg != 2'd0))
        else $error("Emit state entered with no results.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_idx_reg <= lim_reg))
        else $error("Name scan ran past its limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(held_valid_reg) |-> ($past(state_reg) == ST_DECIDE))
        else $error("Held phoneme dropped outside the decision step.");

endmodule

/* test/token_stream_checker.sv */
// Checker for the phoneme token parser: watches the input, result and register channels,
// predicts the token stream from the accepted transactions and compares field by field.
// Depends on ptp_pkg for the result type and the operation, kind and register codes.
module token_stream_checker #(
    parameter int NAME_DEPTH = 128,
    parameter int STRESS_DEPTH = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [7:0]                   ch,
    input  logic [7:0]                   second_ch,
    input  logic [6:0]                   slot,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [1:0]                   kind,
    input  logic [ptp_pkg::PH_W-1:0]     phoneme,
    input  logic [ptp_pkg::STRESS_W-1:0] stress_level,
    input  logic                         last,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [7:0]                   cfg_data,
    output int                           mismatch_count,
    output int                           tokens_owed
);

    import ptp_pkg::*;

    logic [7:0]          first_tab [NAME_DEPTH];
    logic [7:0]          second_tab [NAME_DEPTH];
    logic [7:0]          stress_tab [STRESS_DEPTH];
    logic [7:0]          name_limit;
    logic [7:0]          end_byte;
    logic [7:0]          look_byte;
    logic                look_valid;
    logic [PH_W-1:0]     held_ph;
    logic [STRESS_W-1:0] held_st;
    logic                held_valid;
    int                  fail_total;
    result_t             owed_tokens [$];

    function automatic int scan_limit();
        return (name_limit > NAME_DEPTH) ? NAME_DEPTH : int'(name_limit);
    endfunction

    function automatic int match_pair(input logic [7:0] a, input logic [7:0] b);
        int lim;
        lim = scan_limit();
        for (int i = 0; i < lim; i++)
        begin
            if (first_tab[i] == a && second_tab[i] != WILDCARD && second_tab[i] == b)
                return i;
        end
        return -1;
    endfunction

    function automatic int match_wild(input logic [7:0] a);
        int lim;
        lim = scan_limit();
        for (int i = 0; i < lim; i++)
        begin
            if (second_tab[i] == WILDCARD && first_tab[i] == a)
                return i;
        end
        return -1;
    endfunction

    function automatic int match_stress(input logic [7:0] a);
        for (int i = STRESS_DEPTH - 1; i > 0; i--)
        begin
            if (stress_tab[i] == a)
                return i;
        end
        return 0;
    endfunction

    task automatic push_token(input logic [1:0] k, input int ph, input int st, input logic fin);
        result_t r;
        r.kind = k;
        r.phoneme = PH_W'(ph);
        r.stress_level = STRESS_W'(st);
        r.last = fin;
        owed_tokens.push_back(r);
    endtask

    task automatic drop_held();
        held_valid = 1'b0;
        held_ph = '0;
        held_st = '0;
    endtask

    task automatic hold_phoneme(input int idx);
        if (held_valid)
            push_token(KIND_PHONEME, int'(held_ph), int'(held_st), 1'b0);
        held_ph = PH_W'(idx);
        held_st = '0;
        held_valid = 1'b1;
    endtask

    task automatic tokenize_byte(input logic [1:0] o, input logic [7:0] c,
                                 input logic [7:0] c2, input logic [6:0] s);
        logic [7:0] p;
        int m;
        int st;
        if (o == OP_LOAD_NAME)
        begin
            first_tab[s] = c;
            second_tab[s] = c2;
            return;
        end
        if (o == OP_LOAD_STRESS)
        begin
            if (s < STRESS_DEPTH)
                stress_tab[s] = c;
            return;
        end
        if (o != OP_PARSE)
            return;
        if (look_valid)
        begin
            p = look_byte;
            look_valid = 1'b0;
            m = -1;
            if (c != end_byte)
                m = match_pair(p, c);
            if (m >= 0)
            begin
                hold_phoneme(m);
                return;
            end
            m = match_wild(p);
            if (m >= 0)
                hold_phoneme(m);
            else
            begin
                st = match_stress(p);
                if (st == 0)
                begin
                    push_token(KIND_ERROR, 0, 0, 1'b1);
                    drop_held();
                    return;
                end
                if (held_valid)
                    held_st = STRESS_W'(st);
            end
        end
        if (c == end_byte)
        begin
            if (held_valid)
                push_token(KIND_PHONEME, int'(held_ph), int'(held_st), 1'b1);
            else
                push_token(KIND_END, 0, 0, 1'b1);
            drop_held();
        end
        else
        begin
            look_byte = c;
            look_valid = 1'b1;
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            name_limit = NAME_COUNT_RST;
            end_byte = END_MARKER_RST;
            look_byte = '0;
            look_valid = 1'b0;
            drop_held();
            owed_tokens.delete();
            fail_total = 0;
            mismatch_count <= 0;
            tokens_owed <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_tokens.size() == 0)
                begin
                    $error("unexpected result: kind %0d phoneme %0d stress_level %0d last %0d",
                           kind, phoneme, stress_level, last);
                    fail_total++;
                end
                else
                begin
                    want = owed_tokens.pop_front();
                    check_field("kind", 8'(want.kind), 8'(kind));
                    check_field("phoneme", 8'(want.phoneme), 8'(phoneme));
                    check_field("stress_level", 8'(want.stress_level), 8'(stress_level));
                    check_field("last", 8'(want.last), 8'(last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NAME_COUNT: name_limit = cfg_data;
                    CFG_END_MARKER: end_byte = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                tokenize_byte(op, ch, second_ch, slot);
            mismatch_count <= fail_total;
            tokens_owed <= owed_tokens.size();
        end
    end

endmodule

/* test/tb_top.sv */
// Top of the phoneme token parser testbench: clock, reset, stimulus and verdict.
// Drives phoneme text, table loads and register writes with random idling on both sides;
// depends on ptp_pkg, phoneme_token_parser_core and token_stream_checker.
module tb_top;
    import ptp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          op;
    logic [7:0]          ch;
    logic [7:0]          second_ch;
    logic [6:0]          slot;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          kind;
    logic [PH_W-1:0]     phoneme;
    logic [STRESS_W-1:0] stress_level;
    logic                last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [7:0]          cfg_data;
    int                  mismatch_count;
    int                  tokens_owed;

    logic                stalls_on = 1'b0;
    int                  stall_left = 0;
    bit                  gaps_on;
    int                  items_sent;
    logic [7:0]          name_lim;
    logic [7:0]          end_byte;
    logic [7:0]          tab_first [128];
    logic [7:0]          tab_second [128];
    logic [7:0]          tab_stress [9];

    phoneme_token_parser_core u_dut (.*);

    token_stream_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_item(input logic [1:0] o, input logic [7:0] c,
                             input logic [7:0] c2, input logic [6:0] s);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        ch <= c;
        second_ch <= c2;
        slot <= s;
        do @(posedge clk); while (in_stall);
        if (o != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_parse(input logic [7:0] c);
        send_item(OP_PARSE, c, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_parse((s[i] == ".") ? end_byte : s[i]);
        end
    endtask

    function automatic logic [7:0] pick_letter();
        string set;
        set = "BDFGHIKLMOPRSTUVW";
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic load_names();
        logic [7:0] f;
        logic [7:0] s;
        int r;
        for (int i = 0; i < 128; i++)
        begin
            f = pick_letter();
            r = $urandom_range(0, 3);
            s = (r == 0) ? WILDCARD : (r == 3) ? 8'($urandom_range(0, 255)) : pick_letter();
            case (i)
                0: {f, s} = "AA";
                1: {f, s} = "AE";
                2: {f, s} = "A*";
                3: {f, s} = "AA";
                4: {f, s} = "E*";
                5: {f, s} = "E*";
                6: {f, s} = {"N", END_MARKER_RST};
                8: {f, s} = "N*";
                100: {f, s} = "QQ";
                127: {f, s} = "Z*";
                default: ;
            endcase
            tab_first[i] = f;
            tab_second[i] = s;
            send_item(OP_LOAD_NAME, f, s, 7'(i));
        end
    endtask

    task automatic load_stress();
        string set;
        set = "012!456!8";
        for (int i = 0; i < 9; i++)
        begin
            tab_stress[i] = set[i];
            send_item(OP_LOAD_STRESS, set[i], 8'($urandom_range(0, 255)), 7'(i));
        end
        send_item(OP_LOAD_STRESS, "3", 8'($urandom_range(0, 255)), 7'd12);
        send_item(OP_LOAD_STRESS, 8'hFF, 8'($urandom_range(0, 255)), 7'd127);
    endtask

    task automatic send_word();
        int lim;
        int idx;
        lim = (name_lim > 128) ? 128 : int'(name_lim);
        repeat ($urandom_range(1, 4))
        begin
            idx = (lim == 0) ? $urandom_range(0, 127) : $urandom_range(0, lim - 1);
            send_parse(tab_first[idx]);
            if (tab_second[idx] != WILDCARD)
                send_parse(tab_second[idx]);
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
                send_parse(tab_stress[$urandom_range(1, 8)]);
        end
        if ($urandom_range(0, 9) != 0)
            send_parse(end_byte);
    endtask

    task automatic send_noise();
        logic [7:0] f;
        logic [7:0] s;
        logic [6:0] idx;
        f = 8'($urandom_range(0, 255));
        s = ($urandom_range(0, 3) == 0) ? WILDCARD : 8'($urandom_range(0, 255));
        idx = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 9))
            6:
            begin
                tab_first[idx] = f;
                tab_second[idx] = s;
                send_item(OP_LOAD_NAME, f, s, idx);
            end
            7:
            begin
                if (idx < 9)
                    tab_stress[idx] = f;
                send_item(OP_LOAD_STRESS, f, s, idx);
            end
            8: send_item(OP_UNUSED, f, s, idx);
            9: send_parse(end_byte);
            default: send_parse(f);
        endcase
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_word();
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (tokens_owed != 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] count, input logic [7:0] marker);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NAME_COUNT;
        cfg_data <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_END_MARKER;
        cfg_data <= marker;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        name_lim = count;
        end_byte = marker;
    endtask

    initial
    begin
        #8_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_PARSE;
        ch = '0;
        second_ch = '0;
        slot = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NAME_COUNT;
        cfg_data = '0;
        gaps_on = 1'b1;
        items_sent = 0;
        name_lim = NAME_COUNT_RST;
        end_byte = END_MARKER_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        stalls_on <= 1'b1;
        @(posedge clk);

        load_names();
        load_stress();
        send_text("1.AA.AE2!.AN.EE.A0A.3..QQ.");
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 7'h7F);
        settle();

        set_config(8'd128, END_MARKER_RST);
        send_text("QQ.Z.");
        run_random(75);
        settle();

        set_config(8'd255, 8'h00);
        run_random(50);
        settle();

        set_config(8'd0, 8'hFF);
        run_random(20);
        settle();

        set_config(8'd1, ".");
        run_random(30);
        settle();

        set_config(NAME_COUNT_RST, END_MARKER_RST);
        load_names();
        run_random(75);

        gaps_on = 1'b0;
        stalls_on <= 1'b0;
        run_random(50);
        settle();

        if (mismatch_count == 0 && tokens_owed == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
